>>> rtl/core/peu_pkg.sv
// shared types and constants for the particle euler update block
// no dependencies; used by peu_datapath and the top level

package peu_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int STEP_FRAC     = 16;
  localparam int CFG_DATA_W    = 22;
  localparam int CFG_INDEX_W   = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_TIME_STEP = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRAVITY   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DRAG      = 2'd2;

  localparam logic [15:0] TIME_STEP_RST = 16'd1092;
  localparam logic [21:0] GRAVITY_RST   = 22'd642908;
  localparam logic [21:0] DRAG_RST      = 22'd0;

  typedef struct packed {
    logic [15:0] time_step;
    logic [21:0] gravity_accel;
    logic [21:0] drag_rate;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] life_left;
    logic               gravity_on;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic signed [31:0] new_life_left;
    logic               keeps_gravity;
  } out_item_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/peu_in_if.sv
// particle input channel: valid/ready handshake with the particle fields
// depends on nothing

interface peu_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic signed [31:0] life_left;
  logic               gravity_on;

  modport source (
    output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, life_left, gravity_on,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, life_left, gravity_on,
    output ready
  );
endinterface

>>> rtl/core/peu_out_if.sv
// updated particle channel: valid/ready handshake with the result fields
// depends on nothing

interface peu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_pos_x;
  logic signed [31:0] new_pos_y;
  logic signed [31:0] new_pos_z;
  logic signed [31:0] new_vel_x;
  logic signed [31:0] new_vel_y;
  logic signed [31:0] new_vel_z;
  logic signed [31:0] new_life_left;
  logic               keeps_gravity;

  modport source (
    output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
           new_life_left, keeps_gravity,
    input  ready
  );
  modport sink (
    input  valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
           new_life_left, keeps_gravity,
    output ready
  );
endinterface

>>> rtl/core/peu_datapath.sv
// six-stage payload pipeline: gravity, drag scale, position update, life
// depends on peu_pkg; valid bits and handshake live in the top level

module peu_datapath #(
  parameter int FRAC_BITS = peu_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                advance,
  input  peu_pkg::cfg_t       cfg,
  input  peu_pkg::in_item_t   in_item,
  output logic                alive,
  output peu_pkg::out_item_t  out_item
);

  localparam int FW  = FRAC_BITS + 1;
  localparam int CW  = (FRAC_BITS + 2 > 23) ? FRAC_BITS + 2 : 23;
  localparam int PW1 = 32 + FW + 1;
  localparam int PW2 = 32 + 17;
  localparam int TFW = 16 + FRAC_BITS;
  localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;

  // config-derived terms
  logic [37:0]   grav_prod;
  logic [37:0]   drag_prod;
  logic [21:0]   dv_q;
  logic [21:0]   drag_dt_q;
  logic [FW-1:0] factor_q;
  logic [FW-1:0] factor_next;

  assign grav_prod = 38'(cfg.gravity_accel) * 38'(cfg.time_step);
  assign drag_prod = 38'(cfg.drag_rate) * 38'(cfg.time_step);

  always_comb begin
    if (CW'(drag_dt_q) >= ONE) begin
      factor_next = '0;
    end else begin
      factor_next = FW'(ONE - CW'(drag_dt_q));
    end
  end

  always_ff @(posedge clk) begin
    dv_q      <= grav_prod[37:16];
    drag_dt_q <= drag_prod[37:16];
    factor_q  <= factor_next;
  end

  // stage 1: input register
  peu_pkg::in_item_t s1;

  always_ff @(posedge clk) begin
    if (advance) begin
      s1 <= in_item;
    end
  end

  // stage 2: gravity on vertical velocity, life
  logic [TFW-1:0]          ts_wide;
  logic [FRAC_BITS-1:0]    ts_fb;
  logic signed [32:0]      vy_diff;
  logic signed [32:0]      life_diff;
  logic signed [31:0]      life_sat;
  logic signed [31:0]      vy_sat;

  assign ts_wide   = {cfg.time_step, FRAC_BITS'(0)};
  assign ts_fb     = ts_wide[TFW-1:16];
  assign vy_diff   = 33'(s1.vel_y) - $signed({11'b0, dv_q});
  assign life_diff = 33'(s1.life_left) - $signed(33'(ts_fb));
  assign vy_sat    = s1.gravity_on ? peu_pkg::sat32(64'(vy_diff)) : s1.vel_y;
  assign life_sat  = peu_pkg::sat32(64'(life_diff));
  assign alive     = (life_sat > 32'sd0);

  logic signed [31:0] s2_pos [3];
  logic signed [31:0] s2_vel [3];
  logic signed [31:0] s2_life;
  logic               s2_grav;

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_pos[0] <= s1.pos_x;
      s2_pos[1] <= s1.pos_y;
      s2_pos[2] <= s1.pos_z;
      s2_vel[0] <= s1.vel_x;
      s2_vel[1] <= vy_sat;
      s2_vel[2] <= s1.vel_z;
      s2_life   <= life_sat;
      s2_grav   <= s1.gravity_on;
    end
  end

  // stage 3: velocity times drag factor
  logic signed [PW1-1:0] drag_mul [3];
  logic signed [PW1-1:0] s3_prod  [3];
  logic signed [31:0]    s3_pos   [3];
  logic signed [31:0]    s3_life;
  logic                  s3_grav;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      drag_mul[i] = PW1'(s2_vel[i]) * $signed({1'b0, factor_q});
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_prod <= drag_mul;
      s3_pos  <= s2_pos;
      s3_life <= s2_life;
      s3_grav <= s2_grav;
    end
  end

  // stage 4: floor shift and saturate velocity
  logic signed [PW1-FRAC_BITS-1:0] vel_shr [3];
  logic signed [31:0]              vel_new [3];
  logic signed [31:0]              s4_vel  [3];
  logic signed [31:0]              s4_pos  [3];
  logic signed [31:0]              s4_life;
  logic                            s4_grav;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vel_shr[i] = s3_prod[i][PW1-1:FRAC_BITS];
      vel_new[i] = peu_pkg::sat32(64'(vel_shr[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_vel  <= vel_new;
      s4_pos  <= s3_pos;
      s4_life <= s3_life;
      s4_grav <= s3_grav;
    end
  end

  // stage 5: velocity times step
  logic signed [PW2-1:0] step_mul [3];
  logic signed [PW2-1:0] s5_prod  [3];
  logic signed [31:0]    s5_vel   [3];
  logic signed [31:0]    s5_pos   [3];
  logic signed [31:0]    s5_life;
  logic                  s5_grav;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      step_mul[i] = PW2'(s4_vel[i]) * $signed({1'b0, cfg.time_step});
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s5_prod <= step_mul;
      s5_vel  <= s4_vel;
      s5_pos  <= s4_pos;
      s5_life <= s4_life;
      s5_grav <= s4_grav;
    end
  end

  // stage 6: position sum, output register
  logic signed [PW2-17:0] dpos    [3];
  logic signed [33:0]     pos_sum [3];
  logic signed [31:0]     pos_new [3];
  logic signed [31:0]     s6_pos  [3];
  logic signed [31:0]     s6_vel  [3];
  logic signed [31:0]     s6_life;
  logic                   s6_grav;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dpos[i]    = s5_prod[i][PW2-1:16];
      pos_sum[i] = 34'(s5_pos[i]) + 34'(dpos[i]);
      pos_new[i] = peu_pkg::sat32(64'(pos_sum[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s6_pos  <= pos_new;
      s6_vel  <= s5_vel;
      s6_life <= s5_life;
      s6_grav <= s5_grav;
    end
  end

  assign out_item.new_pos_x     = s6_pos[0];
  assign out_item.new_pos_y     = s6_pos[1];
  assign out_item.new_pos_z     = s6_pos[2];
  assign out_item.new_vel_x     = s6_vel[0];
  assign out_item.new_vel_y     = s6_vel[1];
  assign out_item.new_vel_z     = s6_vel[2];
  assign out_item.new_life_left = s6_life;
  assign out_item.keeps_gravity = s6_grav;

endmodule

>>> rtl/core/particle_euler_update_top.sv
// top level of the particle euler update block: config registers, valid pipeline
// depends on peu_pkg, peu_in_if, peu_out_if and peu_datapath
//
//   channel  dir  handshake        payload
//   in       in   valid/ready      pos, vel, life_left, gravity_on
//   out      out  valid/ready      new_pos, new_vel, new_life_left, keeps_gravity
//   cfg      in   cfg_wr_en        cfg_index, cfg_data
//
// one particle per cycle while the output is not held; each passes all six payload registers
// the six payload stages include two multiplier stages, each followed by a register
// particles whose life ends are dropped at stage two and leave a bubble
// reset clears the valid bits and loads the register defaults, no clearing pass
// a held output stalls the whole pipeline; nothing is lost or repeated

module particle_euler_update_top #(
  parameter int FRAC_BITS = peu_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  peu_in_if.sink                              in,
  peu_out_if.source                           out,
  input  logic                                cfg_wr_en,
  input  logic [peu_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [peu_pkg::CFG_DATA_W-1:0]      cfg_data
);

  peu_pkg::cfg_t      cfg;
  peu_pkg::in_item_t  in_item;
  peu_pkg::out_item_t out_item;
  logic [5:0]         vld;
  logic               advance;
  logic               alive;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.time_step     <= peu_pkg::TIME_STEP_RST;
      cfg.gravity_accel <= peu_pkg::GRAVITY_RST;
      cfg.drag_rate     <= peu_pkg::DRAG_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        peu_pkg::REG_TIME_STEP: cfg.time_step     <= cfg_data[15:0];
        peu_pkg::REG_GRAVITY:   cfg.gravity_accel <= cfg_data;
        peu_pkg::REG_DRAG:      cfg.drag_rate     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance  = !(vld[5] && !out.ready);
  assign in.ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[4:1], vld[0] && alive, in.valid};
    end
  end

  assign in_item.pos_x      = in.pos_x;
  assign in_item.pos_y      = in.pos_y;
  assign in_item.pos_z      = in.pos_z;
  assign in_item.vel_x      = in.vel_x;
  assign in_item.vel_y      = in.vel_y;
  assign in_item.vel_z      = in.vel_z;
  assign in_item.life_left  = in.life_left;
  assign in_item.gravity_on = in.gravity_on;

  peu_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .advance  (advance),
    .cfg      (cfg),
    .in_item  (in_item),
    .alive    (alive),
    .out_item (out_item)
  );

  assign out.valid         = vld[5];
  assign out.new_pos_x     = out_item.new_pos_x;
  assign out.new_pos_y     = out_item.new_pos_y;
  assign out.new_pos_z     = out_item.new_pos_z;
  assign out.new_vel_x     = out_item.new_vel_x;
  assign out.new_vel_y     = out_item.new_vel_y;
  assign out.new_vel_z     = out_item.new_vel_z;
  assign out.new_life_left = out_item.new_life_left;
  assign out.keeps_gravity = out_item.keeps_gravity;

`ifndef SYNTHESIS
  a_stall_holds_valids: assert property (@(posedge clk) disable iff (rst)
    (vld[5] && !out.ready) |=> $stable(vld))
    else $error("valid bits moved during a stall");

  a_result_alive: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> ($signed(out.new_life_left) > 32'sd0))
    else $error("result with expired life");

  a_reset_empties: assert property (@(posedge clk)
    $past(rst) |-> (vld == '0))
    else $error("pipeline not empty after reset");

  a_transfer_enters: assert property (@(posedge clk) disable iff (rst)
    (in.valid && in.ready) |=> vld[0])
    else $error("input transfer did not enter stage one");
`endif

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// testbench for particle_euler_update_top: streams particles under several register
// settings, predicts each euler step in fixed point and checks every result transfer
// depends on peu_pkg, peu_in_if, peu_out_if and the block's top level

module testbench;

  localparam logic [peu_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] WORD_MIN = 32'sh80000000;
  localparam int SETTLE_CYCLES = 12;
  localparam int BATCH_ITEMS = 50;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [peu_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [peu_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  peu_in_if particle_in ();
  peu_out_if particle_out ();

  particle_euler_update_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in        (particle_in),
    .out       (particle_out),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  logic [15:0] step_cfg = peu_pkg::TIME_STEP_RST;
  logic [21:0] gravity_cfg = peu_pkg::GRAVITY_RST;
  logic [21:0] drag_cfg = peu_pkg::DRAG_RST;

  peu_pkg::in_item_t particle_q[$];
  peu_pkg::out_item_t update_q[$];
  peu_pkg::in_item_t sent_particle;
  bit idling_on = 1'b1;
  int send_gap;
  int recv_gap;
  int mismatch_count = 0;

  function automatic longint clamp_word(input longint x);
    if (x > 64'sd2147483647) begin
      return 64'sd2147483647;
    end else if (x < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return x;
  endfunction

  function automatic bit advance_particle(input peu_pkg::in_item_t p,
                                          output peu_pkg::out_item_t upd);
    longint pos [3];
    longint vel [3];
    longint step;
    longint factor;
    longint life;
    step = step_cfg;
    pos[0] = p.pos_x;
    pos[1] = p.pos_y;
    pos[2] = p.pos_z;
    vel[0] = p.vel_x;
    vel[1] = p.vel_y;
    vel[2] = p.vel_z;
    if (p.gravity_on) begin
      vel[1] = clamp_word(vel[1] - ((longint'(gravity_cfg) * step) >>> peu_pkg::STEP_FRAC));
    end
    factor = (longint'(1) << peu_pkg::FRAC_BITS_DEF) -
             ((longint'(drag_cfg) * step) >>> peu_pkg::STEP_FRAC);
    if (factor < 0) begin
      factor = 0;
    end
    for (int i = 0; i < 3; i++) begin
      vel[i] = clamp_word((vel[i] * factor) >>> peu_pkg::FRAC_BITS_DEF);
      pos[i] = clamp_word(pos[i] + ((vel[i] * step) >>> peu_pkg::STEP_FRAC));
    end
    life = clamp_word(longint'(p.life_left) - step);
    upd.new_pos_x = pos[0][31:0];
    upd.new_pos_y = pos[1][31:0];
    upd.new_pos_z = pos[2][31:0];
    upd.new_vel_x = vel[0][31:0];
    upd.new_vel_y = vel[1][31:0];
    upd.new_vel_z = vel[2][31:0];
    upd.new_life_left = life[31:0];
    upd.keeps_gravity = p.gravity_on;
    return life > 0;
  endfunction

  function automatic peu_pkg::in_item_t make_particle(
    input logic signed [31:0] px, py, pz, vx, vy, vz, life,
    input logic grav
  );
    peu_pkg::in_item_t p;
    p.pos_x = px;
    p.pos_y = py;
    p.pos_z = pz;
    p.vel_x = vx;
    p.vel_y = vy;
    p.vel_z = vz;
    p.life_left = life;
    p.gravity_on = grav;
    return p;
  endfunction

  function automatic void queue_particle(input peu_pkg::in_item_t p);
    particle_q.insert(particle_q.size(), p);
  endfunction

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return 32'sd0;
      3, 4, 5: return $urandom;
      default: return $urandom_range(0, 2097152) - 1048576;
    endcase
  endfunction

  function automatic peu_pkg::in_item_t random_particle();
    logic signed [31:0] life;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: life = $urandom_range(1, 32'h7fffffff);
      6: life = step_cfg + $urandom_range(0, 2) - 1;
      7: life = $urandom;
      8: life = $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
      default: life = $urandom_range(0, 8192) - 4096;
    endcase
    return make_particle(pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
                         pick_word(), life, 1'($urandom_range(0, 1)));
  endfunction

  task automatic write_reg(input logic [peu_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [peu_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      peu_pkg::REG_TIME_STEP: step_cfg = data[15:0];
      peu_pkg::REG_GRAVITY: gravity_cfg = data[21:0];
      peu_pkg::REG_DRAG: drag_cfg = data[21:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] ts, input logic [21:0] grav,
                            input logic [21:0] drag);
    write_reg(peu_pkg::REG_TIME_STEP, {6'd0, ts});
    write_reg(peu_pkg::REG_GRAVITY, grav);
    write_reg(peu_pkg::REG_DRAG, drag);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic load_random_config();
    logic [15:0] ts;
    logic [21:0] grav;
    logic [21:0] drag;
    case ($urandom_range(0, 4))
      0: ts = 16'hffff;
      1: ts = 16'($urandom_range(0, 65535));
      default: ts = 16'($urandom_range(1, 4096));
    endcase
    case ($urandom_range(0, 3))
      0: grav = '0;
      1: grav = 22'h3fffff;
      default: grav = 22'($urandom_range(0, 22'h3fffff));
    endcase
    case ($urandom_range(0, 5))
      0: drag = '0;
      1: drag = 22'($urandom_range(0, 22'h3fffff));
      2: drag = 22'h3fffff;
      default: drag = 22'($urandom_range(0, 1 << 18));
    endcase
    if ($urandom_range(0, 3) == 0) begin
      write_reg(REG_SPARE, 22'($urandom_range(0, 22'h3fffff)));
    end
    set_config(ts, grav, drag);
  endtask

  // block is idle once nothing is queued, in flight or expected
  task automatic drain();
    while (particle_q.size() != 0 || particle_in.valid || update_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : drive_particles
    peu_pkg::out_item_t upd;
    peu_pkg::in_item_t nxt;
    if (rst) begin
      particle_in.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (particle_in.valid && particle_in.ready) begin
        if (advance_particle(sent_particle, upd)) begin
          update_q.insert(update_q.size(), upd);
        end
      end
      if (!particle_in.valid || particle_in.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          particle_in.valid <= 1'b0;
        end else if (particle_q.size() != 0) begin
          nxt = particle_q.pop_front();
          sent_particle <= nxt;
          particle_in.pos_x <= nxt.pos_x;
          particle_in.pos_y <= nxt.pos_y;
          particle_in.pos_z <= nxt.pos_z;
          particle_in.vel_x <= nxt.vel_x;
          particle_in.vel_y <= nxt.vel_y;
          particle_in.vel_z <= nxt.vel_z;
          particle_in.life_left <= nxt.life_left;
          particle_in.gravity_on <= nxt.gravity_on;
          particle_in.valid <= 1'b1;
          if (idling_on && $urandom_range(0, 5) == 0) begin
            send_gap <= $urandom_range(1, 8);
          end
        end else begin
          particle_in.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_updates
    peu_pkg::out_item_t got;
    peu_pkg::out_item_t want;
    if (rst) begin
      particle_out.ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (particle_out.valid && particle_out.ready) begin
        got.new_pos_x = particle_out.new_pos_x;
        got.new_pos_y = particle_out.new_pos_y;
        got.new_pos_z = particle_out.new_pos_z;
        got.new_vel_x = particle_out.new_vel_x;
        got.new_vel_y = particle_out.new_vel_y;
        got.new_vel_z = particle_out.new_vel_z;
        got.new_life_left = particle_out.new_life_left;
        got.keeps_gravity = particle_out.keeps_gravity;
        if (update_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch at %0t: result transfer with nothing expected", $realtime);
          end
        end else begin
          want = update_q.pop_front();
          if (got.new_pos_x !== want.new_pos_x || got.new_pos_y !== want.new_pos_y ||
              got.new_pos_z !== want.new_pos_z || got.new_vel_x !== want.new_vel_x ||
              got.new_vel_y !== want.new_vel_y || got.new_vel_z !== want.new_vel_z ||
              got.new_life_left !== want.new_life_left ||
              got.keeps_gravity !== want.keeps_gravity) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch at %0t", $realtime);
              $display("  expected pos %h %h %h vel %h %h %h life %h grav %b",
                       want.new_pos_x, want.new_pos_y, want.new_pos_z, want.new_vel_x,
                       want.new_vel_y, want.new_vel_z, want.new_life_left, want.keeps_gravity);
              $display("  actual   pos %h %h %h vel %h %h %h life %h grav %b",
                       got.new_pos_x, got.new_pos_y, got.new_pos_z, got.new_vel_x,
                       got.new_vel_y, got.new_vel_z, got.new_life_left, got.keeps_gravity);
            end
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        particle_out.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        recv_gap <= $urandom_range(0, 7);
        particle_out.ready <= 1'b0;
      end else begin
        particle_out.ready <= 1'b1;
      end
    end
  end

  initial begin : run_test
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // register defaults: life boundary, saturation, floor of negative products
    queue_particle(make_particle(0, 0, 0, 0, 0, 0, 1093, 1'b0));
    queue_particle(make_particle(0, 0, 0, 0, 0, 0, 1092, 1'b1));
    queue_particle(make_particle(0, 0, 0, 0, 0, 0, 0, 1'b0));
    queue_particle(make_particle(0, 0, 0, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN, 1'b1));
    queue_particle(make_particle(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
                                 WORD_MAX, WORD_MAX, 1'b1));
    queue_particle(make_particle(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
                                 WORD_MIN, WORD_MAX, 1'b1));
    queue_particle(make_particle(0, 0, 0, -1, -1, -1, 65536, 1'b0));
    queue_particle(make_particle(5, -5, 7, 1, 1, 1, 65536, 1'b1));
    queue_particle(make_particle(100 << 16, -(3 << 16), 1 << 16, 2 << 16, 10 << 16,
                                 -(4 << 16), 2 << 16, 1'b1));
    queue_particle(make_particle(0, 0, 0, 0, 0, 0, -1, 1'b1));
    queue_particle(make_particle(0, 0, 0, 0, WORD_MIN + 5, 0, WORD_MAX, 1'b1));
    drain();

    // drag just short of stopping the particle
    set_config(16'hffff, 22'h3fffff, 22'd65537);
    queue_particle(make_particle(0, 0, 0, WORD_MAX, WORD_MAX, WORD_MIN, 65536, 1'b1));
    queue_particle(make_particle(WORD_MAX, WORD_MIN, 0, 12345678, -12345678, 0, 65536,
                                 1'b0));
    queue_particle(make_particle(0, 0, 0, 0, 0, 0, 65535, 1'b1));
    drain();

    // heavy drag clamps the scale to zero
    set_config(16'hffff, 22'h3fffff, 22'd65538);
    queue_particle(make_particle(1, 2, 3, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MAX, 1'b1));
    queue_particle(make_particle(-1, -2, -3, WORD_MIN, WORD_MAX, WORD_MIN, 70000, 1'b0));
    drain();

    // write to an unused index, then a zero time step
    write_reg(REG_SPARE, 22'h3fffff);
    set_config(16'd0, 22'd0, 22'd0);
    queue_particle(make_particle(WORD_MAX, WORD_MIN, 0, WORD_MAX, WORD_MIN, -7, 1, 1'b1));
    queue_particle(make_particle(0, 0, 0, 0, 0, 0, 0, 1'b1));
    queue_particle(make_particle(0, 0, 0, 0, 0, 0, WORD_MIN, 1'b0));
    drain();

    set_config(16'hffff, 22'h3fffff, 22'd0);
    queue_particle(make_particle(0, 0, 0, 0, WORD_MIN, 0, WORD_MAX, 1'b1));
    queue_particle(make_particle(WORD_MIN, WORD_MAX, 0, WORD_MIN, WORD_MAX, WORD_MAX,
                                 WORD_MAX, 1'b1));
    drain();

    for (int k = 0; k < 8; k++) begin
      load_random_config();
      idling_on = (k != 2 && k != 7);
      for (int n = 0; n < BATCH_ITEMS; n++) begin
        queue_particle(random_particle());
      end
      drain();
    end

    if (mismatch_count == 0 && update_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
